// ----- src/lodq_pkg.sv -----
// Shared types and constants for the level-of-detail request queue.
`default_nettype none
package lodq_pkg;
    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int COORD_W = 24;
    localparam int DIST_W = 50;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_REMOVE = 3'd1;
    localparam logic [2:0] FUNC_SORT_NEW = 3'd2;
    localparam logic [2:0] FUNC_SORT_LAST = 3'd3;
    localparam logic [2:0] FUNC_POLL = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RM_READ,
        ST_RM_CHECK,
        ST_SHIFT_READ,
        ST_SHIFT_WRITE,
        ST_DIST_READ,
        ST_DIST_CALC,
        ST_DIST_WRITE,
        ST_INS_READ,
        ST_INS_CMP,
        ST_INS_MOVE,
        ST_INS_PLACE,
        ST_HEAD_READ,
        ST_HEAD_LATCH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] node;
        logic [4:0] level;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
    } entry_t;
endpackage
`default_nettype wire

// ----- src/lodq_sq_unit.sv -----
// Shared squared-distance unit: one axis per cycle, accumulating the sum.
`default_nettype none
module lodq_sq_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [lodq_pkg::COORD_W-1:0] a,
    input  wire logic signed [lodq_pkg::COORD_W-1:0] b,
    output logic [lodq_pkg::DIST_W-1:0] sum
);
    localparam int MW = lodq_pkg::COORD_W + 1;

    logic [MW-1:0] mag_reg;
    logic [MW-1:0] mag_next;
    logic signed [MW-1:0] diff;
    logic [lodq_pkg::DIST_W-1:0] sq;
    logic [lodq_pkg::DIST_W-1:0] sum_reg;

    assign diff = MW'(a) - MW'(b);
    assign mag_next = diff[MW-1] ? MW'(-diff) : diff;
    assign sq = lodq_pkg::DIST_W'(mag_reg) * lodq_pkg::DIST_W'(mag_reg);
    assign sum = sum_reg;

    // The square of the previous axis is added while the next difference forms.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            mag_reg <= mag_next;
            if (start)
                sum_reg <= '0;
            else
                sum_reg <= sum_reg + sq;
        end
    end
endmodule
`default_nettype wire

// ----- src/lod_distance_priority_queue.sv -----
// Top level of the level-of-detail request queue.
// The block is not ready while it works on a word. Add, an unused code and poll on
// an empty table read the head entry, latch it and present the result; a remove
// scans the entries for the node and then shifts the tail down one slot; a sort
// first forms every squared distance with one shared subtract-and-square unit,
// then runs an insertion sort over the table memory of 64 entries, which has one
// read and one write port. The result word waits in an output register until
// taken.
`default_nettype none
module lod_distance_priority_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic s_tready,
    // func[2:0], node_id[18:3], detail_level[23:19], center_x[47:24],
    // center_y[71:48], center_z[95:72], view_x[119:96], view_y[143:120],
    // view_z[167:144]
    input  wire logic [167:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // head_valid[0], head_node[16:1], popped_valid[17], popped_node[33:18],
    // add_dropped[34], entry_count[41:35], zero fill [47:42]
    output logic [47:0] m_tdata
);
    localparam int IW = lodq_pkg::IDX_W;
    localparam int CW = lodq_pkg::CNT_W;

    lodq_pkg::state_t state_reg, state_next;
    lodq_pkg::entry_t ent_mem [lodq_pkg::QUEUE_DEPTH];
    logic [lodq_pkg::DIST_W-1:0] dist_mem [lodq_pkg::QUEUE_DEPTH];
    lodq_pkg::entry_t rd_ent_reg;
    logic [lodq_pkg::DIST_W-1:0] rd_dist_reg;

    logic [CW-1:0] count_reg;
    logic [2:0] func_reg;
    logic [15:0] id_reg;
    logic signed [lodq_pkg::COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic [CW-1:0] i_reg, j_reg;
    logic [1:0] axis_reg;
    lodq_pkg::entry_t key_reg;
    logic [lodq_pkg::DIST_W-1:0] key_dist_reg;
    logic popped_v_reg, dropped_reg, head_v_reg;
    logic [15:0] popped_n_reg, head_n_reg;

    logic mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    lodq_pkg::entry_t mem_wdata;
    logic dist_we;
    logic [IW-1:0] dist_waddr;
    logic [lodq_pkg::DIST_W-1:0] dist_wdata;
    logic sq_start;
    logic signed [lodq_pkg::COORD_W-1:0] sq_a, sq_b;
    logic [lodq_pkg::DIST_W-1:0] sq_sum;
    logic key_first;

    lodq_sq_unit u_sq (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .a(sq_a), .b(sq_b), .sum(sq_sum)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            ent_mem[mem_waddr] <= mem_wdata;
        if (dist_we)
            dist_mem[dist_waddr] <= dist_wdata;
        rd_ent_reg <= ent_mem[mem_raddr];
        rd_dist_reg <= dist_mem[mem_raddr];
    end

    assign key_first = (key_reg.level < rd_ent_reg.level) ||
                       (key_reg.level == rd_ent_reg.level && key_dist_reg < rd_dist_reg);

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin sq_a = vx_reg; sq_b = rd_ent_reg.cx; end
            2'd1:    begin sq_a = vy_reg; sq_b = rd_ent_reg.cy; end
            default: begin sq_a = vz_reg; sq_b = rd_ent_reg.cz; end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lodq_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    case (s_tdata[2:0])
                        lodq_pkg::FUNC_REMOVE:
                            state_next = lodq_pkg::ST_RM_READ;
                        lodq_pkg::FUNC_SORT_NEW, lodq_pkg::FUNC_SORT_LAST:
                            state_next = lodq_pkg::ST_DIST_READ;
                        lodq_pkg::FUNC_POLL:
                            state_next = lodq_pkg::ST_HEAD_READ;
                        default:
                            state_next = lodq_pkg::ST_HEAD_READ;
                    endcase
                end
            lodq_pkg::ST_RM_READ:
                state_next = (i_reg < count_reg) ? lodq_pkg::ST_RM_CHECK
                                                 : lodq_pkg::ST_HEAD_READ;
            lodq_pkg::ST_RM_CHECK:
                state_next = (rd_ent_reg.node == id_reg) ? lodq_pkg::ST_SHIFT_READ
                                                         : lodq_pkg::ST_RM_READ;
            lodq_pkg::ST_SHIFT_READ:
                state_next = (i_reg + CW'(1) < count_reg) ? lodq_pkg::ST_SHIFT_WRITE
                                                          : lodq_pkg::ST_HEAD_READ;
            lodq_pkg::ST_SHIFT_WRITE:
                state_next = lodq_pkg::ST_SHIFT_READ;
            lodq_pkg::ST_DIST_READ:
                state_next = (i_reg < count_reg) ? lodq_pkg::ST_DIST_CALC
                                                 : lodq_pkg::ST_INS_READ;
            lodq_pkg::ST_DIST_CALC:
                if (axis_reg == 2'd3)
                    state_next = lodq_pkg::ST_DIST_WRITE;
            lodq_pkg::ST_DIST_WRITE:
                state_next = lodq_pkg::ST_DIST_READ;
            lodq_pkg::ST_INS_READ:
                state_next = (i_reg < count_reg) ? lodq_pkg::ST_INS_CMP
                                                 : lodq_pkg::ST_HEAD_READ;
            lodq_pkg::ST_INS_CMP:
                if (j_reg == '0)
                    state_next = lodq_pkg::ST_INS_PLACE;
                else
                    state_next = lodq_pkg::ST_INS_MOVE;
            lodq_pkg::ST_INS_MOVE:
                state_next = key_first ? lodq_pkg::ST_INS_CMP : lodq_pkg::ST_INS_PLACE;
            lodq_pkg::ST_INS_PLACE:
                state_next = lodq_pkg::ST_INS_READ;
            lodq_pkg::ST_HEAD_READ:
                state_next = lodq_pkg::ST_HEAD_LATCH;
            lodq_pkg::ST_HEAD_LATCH:
                // A poll that finds an entry shifts the rest down and reads the head again.
                state_next = (func_reg == lodq_pkg::FUNC_POLL && count_reg != '0)
                             ? lodq_pkg::ST_SHIFT_READ : lodq_pkg::ST_OUT;
            lodq_pkg::ST_OUT:
                if (m_tready)
                    state_next = lodq_pkg::ST_IDLE;
            default:
                state_next = lodq_pkg::ST_IDLE;
        endcase
    end

    // Memory controls.
    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = rd_ent_reg;
        mem_raddr = i_reg[IW-1:0];
        dist_we = 1'b0;
        dist_waddr = '0;
        dist_wdata = rd_dist_reg;
        sq_start = 1'b0;
        case (state_reg)
            lodq_pkg::ST_IDLE:
            begin
                mem_raddr = '0;
                if (s_tvalid && s_tdata[2:0] == lodq_pkg::FUNC_ADD &&
                    count_reg < CW'(lodq_pkg::QUEUE_DEPTH))
                begin
                    mem_we = 1'b1;
                    mem_waddr = count_reg[IW-1:0];
                    mem_wdata.node = s_tdata[18:3];
                    mem_wdata.level = s_tdata[23:19];
                    mem_wdata.cx = s_tdata[47:24];
                    mem_wdata.cy = s_tdata[71:48];
                    mem_wdata.cz = s_tdata[95:72];
                end
            end
            lodq_pkg::ST_SHIFT_READ:
                mem_raddr = IW'(i_reg + CW'(1));
            lodq_pkg::ST_SHIFT_WRITE:
            begin
                mem_we = 1'b1;
                mem_waddr = i_reg[IW-1:0];
            end
            lodq_pkg::ST_DIST_CALC:
                sq_start = (axis_reg == 2'd0);
            lodq_pkg::ST_DIST_WRITE:
            begin
                dist_we = 1'b1;
                dist_waddr = i_reg[IW-1:0];
                dist_wdata = sq_sum;
            end
            lodq_pkg::ST_INS_CMP:
                mem_raddr = IW'(j_reg - CW'(1));
            lodq_pkg::ST_INS_MOVE:
                if (key_first)
                begin
                    mem_we = 1'b1;
                    mem_waddr = j_reg[IW-1:0];
                    dist_we = 1'b1;
                    dist_waddr = j_reg[IW-1:0];
                end
            lodq_pkg::ST_INS_PLACE:
            begin
                mem_we = 1'b1;
                mem_waddr = j_reg[IW-1:0];
                mem_wdata = key_reg;
                dist_we = 1'b1;
                dist_waddr = j_reg[IW-1:0];
                dist_wdata = key_dist_reg;
            end
            lodq_pkg::ST_HEAD_READ:
                mem_raddr = '0;
            default:
                mem_raddr = i_reg[IW-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lodq_pkg::ST_IDLE;
            count_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
            vz_reg <= '0;
            func_reg <= '0;
            id_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            axis_reg <= '0;
            popped_v_reg <= 1'b0;
            popped_n_reg <= '0;
            dropped_reg <= 1'b0;
            head_v_reg <= 1'b0;
            head_n_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                lodq_pkg::ST_IDLE:
                    if (s_tvalid)
                    begin
                        func_reg <= s_tdata[2:0];
                        id_reg <= s_tdata[18:3];
                        i_reg <= '0;
                        axis_reg <= '0;
                        popped_v_reg <= 1'b0;
                        popped_n_reg <= '0;
                        dropped_reg <= 1'b0;
                        if (s_tdata[2:0] == lodq_pkg::FUNC_ADD)
                        begin
                            if (count_reg < CW'(lodq_pkg::QUEUE_DEPTH))
                                count_reg <= count_reg + CW'(1);
                            else
                                dropped_reg <= 1'b1;
                        end
                        if (s_tdata[2:0] == lodq_pkg::FUNC_SORT_NEW)
                        begin
                            vx_reg <= s_tdata[119:96];
                            vy_reg <= s_tdata[143:120];
                            vz_reg <= s_tdata[167:144];
                        end
                    end
                lodq_pkg::ST_RM_CHECK:
                    if (rd_ent_reg.node != id_reg)
                        i_reg <= i_reg + CW'(1);
                lodq_pkg::ST_SHIFT_READ:
                    if (!(i_reg + CW'(1) < count_reg))
                        count_reg <= count_reg - CW'(1);
                lodq_pkg::ST_SHIFT_WRITE:
                    i_reg <= i_reg + CW'(1);
                lodq_pkg::ST_DIST_READ:
                begin
                    axis_reg <= '0;
                    if (!(i_reg < count_reg))
                        i_reg <= CW'(1);
                end
                lodq_pkg::ST_DIST_CALC:
                    axis_reg <= axis_reg + 2'd1;
                lodq_pkg::ST_DIST_WRITE:
                    i_reg <= i_reg + CW'(1);
                lodq_pkg::ST_INS_READ:
                    j_reg <= i_reg;
                lodq_pkg::ST_INS_MOVE:
                    if (key_first)
                        j_reg <= j_reg - CW'(1);
                lodq_pkg::ST_INS_PLACE:
                    i_reg <= i_reg + CW'(1);
                lodq_pkg::ST_HEAD_LATCH:
                begin
                    head_v_reg <= (count_reg != '0);
                    head_n_reg <= (count_reg != '0) ? rd_ent_reg.node : 16'd0;
                    if (func_reg == lodq_pkg::FUNC_POLL && count_reg != '0)
                    begin
                        // Pop: the head was just read; shift the rest down.
                        popped_v_reg <= 1'b1;
                        popped_n_reg <= rd_ent_reg.node;
                        func_reg <= lodq_pkg::FUNC_REMOVE;
                        i_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The key of the insertion pass is captured when its entry is read.
    always_ff @(posedge clk)
    begin
        if (state_reg == lodq_pkg::ST_INS_CMP && j_reg == i_reg)
        begin
            key_reg <= rd_ent_reg;
            key_dist_reg <= rd_dist_reg;
        end
    end

    // Outputs.
    always_comb
    begin
        s_tready = (state_reg == lodq_pkg::ST_IDLE);
        m_tvalid = (state_reg == lodq_pkg::ST_OUT);
        m_tdata = {6'd0, count_reg, dropped_reg, popped_n_reg, popped_v_reg,
                   head_n_reg, head_v_reg};
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(lodq_pkg::QUEUE_DEPTH))
        else $error("entry count beyond depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("accepting while a result is pending");
endmodule
`default_nettype wire
